// File: rtl/gtp_pkg.sv
// Package for the guillotine rectangle packer.
// Holds sizes, register indexes, payload and free-piece types used by gtp_split and the top level.
// Depends on nothing.
package gtp_pkg;

	localparam int MAX_FREE  = 256;
	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = 13;
	localparam int AREA_W    = 25;
	localparam int IDX_W     = $clog2(MAX_FREE);
	localparam int CNT_W     = $clog2(MAX_FREE + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BIN_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
	} rect_req_t;

	typedef struct packed {
		logic              placed;
		logic [DIM_W-1:0]  pos_x;
		logic [DIM_W-1:0]  pos_y;
		logic              store_full;
		logic [AREA_W-1:0] filled_area;
	} rect_res_t;

	typedef struct packed {
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} piece_t;

	typedef struct packed {
		logic   fits;
		piece_t a;
		piece_t b;
	} split_t;

	localparam int PIECE_W = $bits(piece_t);

endpackage

// File: rtl/gtp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the free-piece list; depends on nothing.
module gtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/gtp_split.sv
// Shared fit-compare and guillotine split unit of the packer.
// Depends on gtp_pkg for the piece and request types.
module gtp_split (
	input  gtp_pkg::piece_t    ent,
	input  gtp_pkg::rect_req_t req,
	output gtp_pkg::split_t    split
);

	logic [gtp_pkg::DIM_W-1:0] lw;
	logic [gtp_pkg::DIM_W-1:0] lh;

	always_comb begin
		lw = ent.w - req.rect_width;
		lh = ent.h - req.rect_height;
		split.fits = (req.rect_width <= ent.w) && (req.rect_height <= ent.h);
		// Cut along the axis with the smaller leftover.
		if (lw <= lh) begin
			split.a.x = ent.x + req.rect_width;
			split.a.y = ent.y;
			split.a.w = lw;
			split.a.h = req.rect_height;
			split.b.x = ent.x;
			split.b.y = ent.y + req.rect_height;
			split.b.w = ent.w;
			split.b.h = lh;
		end else begin
			split.a.x = ent.x;
			split.a.y = ent.y + req.rect_height;
			split.a.w = req.rect_width;
			split.a.h = lh;
			split.b.x = ent.x + req.rect_width;
			split.b.y = ent.y;
			split.b.w = lw;
			split.b.h = ent.h;
		end
	end

endmodule

// File: rtl/guillotine_rect_packer.sv
// Top level of the guillotine rectangle packer: sequencer, free-list RAM and split unit.
// Depends on gtp_pkg, gtp_ram and gtp_split.

// A request is taken when start is high and busy is low. The free list is scanned
// front to back through the single read port of the list RAM, each entry read and then
// compared; on a hit, the entries behind it move back by one place, each read and then
// written, then the two split pieces are written. A miss, or a refusal with a full list,
// goes straight to the result. After each result the packer returns to idle before it
// takes the next item.
// The result is shown for exactly one cycle with done high and must be taken then;
// the receiver cannot stall it. Bin size writes on the cfg port take effect at once,
// need no clearing pass, and must be made only while busy is low.
module guillotine_rect_packer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  gtp_pkg::rect_req_t                req,
	output logic                              done,
	output gtp_pkg::rect_res_t                result,
	input  logic                              cfg_we,
	input  logic [gtp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gtp_pkg::DIM_W-1:0]         cfg_wdata
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_SCAN_RD  = 8'b0000_0010,
		ST_SCAN_CMP = 8'b0000_0100,
		ST_SH_RD    = 8'b0000_1000,
		ST_SH_WR    = 8'b0001_0000,
		ST_WR_A     = 8'b0010_0000,
		ST_WR_B     = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	state_t                      state_q;
	logic [gtp_pkg::DIM_W-1:0]   bin_w_q;
	logic [gtp_pkg::DIM_W-1:0]   bin_h_q;
	logic [gtp_pkg::CNT_W-1:0]   count_q;
	logic [gtp_pkg::AREA_W-1:0]  area_q;
	logic [gtp_pkg::AREA_W-1:0]  prod_q;
	logic                        head_q;
	logic                        ovr_q;
	logic [gtp_pkg::IDX_W-1:0]   idx_q;
	logic [gtp_pkg::IDX_W-1:0]   hit_q;
	logic [gtp_pkg::IDX_W-1:0]   jdx_q;
	gtp_pkg::rect_req_t          req_q;
	gtp_pkg::piece_t             ent_q;
	gtp_pkg::rect_res_t          res_q;

	logic                        ram_we;
	logic [gtp_pkg::IDX_W-1:0]   ram_waddr;
	gtp_pkg::piece_t             ram_wdata;
	logic [gtp_pkg::IDX_W-1:0]   ram_raddr;
	logic [gtp_pkg::PIECE_W-1:0] ram_rdata;
	gtp_pkg::piece_t             rd_ent;
	gtp_pkg::piece_t             unit_ent;
	gtp_pkg::split_t             split;
	logic [gtp_pkg::DIM_W-1:0]   cfg_dim;
	logic                        cfg_hit;
	logic                        last_idx;
	logic [gtp_pkg::IDX_W-1:0]   last_pos;
	logic [2*gtp_pkg::DIM_W-1:0] prod_full;

	gtp_ram #(
		.WIDTH(gtp_pkg::PIECE_W),
		.DEPTH(gtp_pkg::MAX_FREE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	gtp_split u_split (
		.ent  (unit_ent),
		.req  (req_q),
		.split(split)
	);

	// Until a placement rewrites it, entry 0 is the whole bin and comes from the
	// size registers rather than the RAM.
	always_comb begin
		if (ovr_q) begin
			rd_ent = '{x: '0, y: '0, w: bin_w_q, h: bin_h_q};
		end else begin
			rd_ent = gtp_pkg::piece_t'(ram_rdata);
		end
		unit_ent  = (state_q == ST_SCAN_CMP) ? rd_ent : ent_q;
		last_pos  = gtp_pkg::IDX_W'(count_q - gtp_pkg::CNT_W'(1));
		last_idx  = ({1'b0, idx_q} == (count_q - gtp_pkg::CNT_W'(1)));
		cfg_dim   = (cfg_wdata > gtp_pkg::DIM_W'(gtp_pkg::MAX_DIM)) ?
			gtp_pkg::DIM_W'(gtp_pkg::MAX_DIM) : cfg_wdata;
		cfg_hit   = cfg_we && ((cfg_index == gtp_pkg::REG_BIN_WIDTH) ||
			(cfg_index == gtp_pkg::REG_BIN_HEIGHT));
		prod_full = {{gtp_pkg::DIM_W{1'b0}}, req_q.rect_width} *
			{{gtp_pkg::DIM_W{1'b0}}, req_q.rect_height};
	end

	always_comb begin
		ram_raddr = (state_q == ST_SH_RD) ? jdx_q : idx_q;
		ram_we    = 1'b0;
		ram_waddr = hit_q;
		ram_wdata = split.a;
		unique case (state_q)
			ST_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = jdx_q + gtp_pkg::IDX_W'(1);
				ram_wdata = rd_ent;
			end
			ST_WR_A: begin
				ram_we    = 1'b1;
				ram_waddr = hit_q;
				ram_wdata = split.a;
			end
			ST_WR_B: begin
				ram_we    = 1'b1;
				ram_waddr = hit_q + gtp_pkg::IDX_W'(1);
				ram_wdata = split.b;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bin_w_q <= '0;
			bin_h_q <= '0;
			count_q <= gtp_pkg::CNT_W'(1);
			area_q  <= '0;
			head_q  <= 1'b1;
			ovr_q   <= 1'b0;
		end else begin
			ovr_q <= head_q && (ram_raddr == '0) &&
				((state_q == ST_SCAN_RD) || (state_q == ST_SH_RD));
			if (cfg_hit) begin
				if (cfg_index == gtp_pkg::REG_BIN_WIDTH) begin
					bin_w_q <= cfg_dim;
				end else begin
					bin_h_q <= cfg_dim;
				end
				count_q <= gtp_pkg::CNT_W'(1);
				area_q  <= '0;
				head_q  <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					if (split.fits) begin
						if (count_q >= gtp_pkg::CNT_W'(gtp_pkg::MAX_FREE)) begin
							state_q <= ST_DONE;
						end else if (last_pos > idx_q) begin
							state_q <= ST_SH_RD;
						end else begin
							state_q <= ST_WR_A;
						end
					end else if (last_idx) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SH_RD: begin
					state_q <= ST_SH_WR;
				end
				ST_SH_WR: begin
					if (jdx_q == hit_q + gtp_pkg::IDX_W'(1)) begin
						state_q <= ST_WR_A;
					end else begin
						state_q <= ST_SH_RD;
					end
				end
				ST_WR_A: begin
					if (hit_q == '0) begin
						head_q <= 1'b0;
					end
					state_q <= ST_WR_B;
				end
				ST_WR_B: begin
					count_q <= count_q + gtp_pkg::CNT_W'(1);
					area_q  <= area_q + prod_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; these need no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q <= req;
				idx_q <= '0;
			end
			ST_SCAN_CMP: begin
				ent_q <= rd_ent;
				hit_q <= idx_q;
				jdx_q <= last_pos;
				if (!last_idx) begin
					idx_q <= idx_q + gtp_pkg::IDX_W'(1);
				end
				res_q.placed      <= 1'b0;
				res_q.pos_x       <= '0;
				res_q.pos_y       <= '0;
				res_q.store_full  <= split.fits &&
					(count_q >= gtp_pkg::CNT_W'(gtp_pkg::MAX_FREE));
				res_q.filled_area <= area_q;
			end
			ST_SH_WR: begin
				jdx_q <= jdx_q - gtp_pkg::IDX_W'(1);
			end
			ST_WR_A: begin
				prod_q <= prod_full[gtp_pkg::AREA_W-1:0];
			end
			ST_WR_B: begin
				res_q.placed      <= 1'b1;
				res_q.pos_x       <= ent_q.x;
				res_q.pos_y       <= ent_q.y;
				res_q.store_full  <= 1'b0;
				res_q.filled_area <= area_q + prod_q;
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign result = res_q;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("packer did not return to idle after a result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= gtp_pkg::CNT_W'(gtp_pkg::MAX_FREE)))
		else $error("free count out of range");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.placed && result.store_full))
		else $error("result both placed and refused");

	a_shift_behind_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_WR) |-> (jdx_q > hit_q))
		else $error("shift wrote at or before the hit entry");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

endmodule

// File: test/guillotine_rect_packer_tb.sv
// Self-checking testbench for guillotine_rect_packer: directed and random rectangle requests
// against an in-bench first-fit packing predictor. Depends on gtp_pkg and the packer RTL.
`timescale 1ns / 1ps

module guillotine_rect_packer_tb;

	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 750;
	localparam int FILL_ITEMS = gtp_pkg::MAX_FREE - 1;
	localparam logic [gtp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = gtp_pkg::CFG_IDX_W'(2);
	localparam logic [gtp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = gtp_pkg::CFG_IDX_W'(3);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	gtp_pkg::rect_req_t req = '0;
	logic done;
	gtp_pkg::rect_res_t result;
	logic cfg_we = 1'b0;
	logic [gtp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gtp_pkg::DIM_W-1:0] cfg_wdata = '0;

	gtp_pkg::rect_req_t pending_rects[$];
	gtp_pkg::rect_res_t placements_due[$];
	int mismatches = 0;
	int accepted_rects = 0;
	int gap_left = 0;
	int stall_cycles = 0;
	bit idle_en = 1'b1;
	bit calm = 1'b0;

	// Predicted packer state.
	gtp_pkg::piece_t free_list[gtp_pkg::MAX_FREE];
	int free_cnt;
	logic [gtp_pkg::AREA_W-1:0] area_sum;
	int pred_bin_w;
	int pred_bin_h;

	guillotine_rect_packer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void empty_bin();
		for (int i = 0; i < gtp_pkg::MAX_FREE; i++) begin
			free_list[i] = '0;
		end
		free_list[0].w = gtp_pkg::DIM_W'(pred_bin_w);
		free_list[0].h = gtp_pkg::DIM_W'(pred_bin_h);
		free_cnt = 1;
		area_sum = '0;
	endfunction

	// First-fit scan, then a guillotine cut of the hit entry along the shorter leftover.
	function automatic gtp_pkg::rect_res_t place_rect(input gtp_pkg::rect_req_t r);
		gtp_pkg::rect_res_t res;
		gtp_pkg::piece_t e;
		gtp_pkg::piece_t a;
		gtp_pkg::piece_t b;
		int rw;
		int rh;
		int lw;
		int lh;
		int hit;
		bit found;
		res = '0;
		hit = 0;
		found = 1'b0;
		rw = r.rect_width;
		rh = r.rect_height;
		for (int i = 0; i < free_cnt; i++) begin
			if (rw <= free_list[i].w && rh <= free_list[i].h) begin
				hit = i;
				found = 1'b1;
				break;
			end
		end
		if (found && free_cnt >= gtp_pkg::MAX_FREE) begin
			res.store_full = 1'b1;
		end else if (found) begin
			e = free_list[hit];
			lw = e.w - rw;
			lh = e.h - rh;
			if (lw <= lh) begin
				a.x = gtp_pkg::DIM_W'(e.x + rw); a.y = e.y;
				a.w = gtp_pkg::DIM_W'(lw); a.h = gtp_pkg::DIM_W'(rh);
				b.x = e.x; b.y = gtp_pkg::DIM_W'(e.y + rh);
				b.w = e.w; b.h = gtp_pkg::DIM_W'(lh);
			end else begin
				a.x = e.x; a.y = gtp_pkg::DIM_W'(e.y + rh);
				a.w = gtp_pkg::DIM_W'(rw); a.h = gtp_pkg::DIM_W'(lh);
				b.x = gtp_pkg::DIM_W'(e.x + rw); b.y = e.y;
				b.w = gtp_pkg::DIM_W'(lw); b.h = e.h;
			end
			for (int j = free_cnt; j > hit + 1; j--) begin
				free_list[j] = free_list[j-1];
			end
			free_list[hit] = a;
			free_list[hit+1] = b;
			free_cnt++;
			area_sum = area_sum + gtp_pkg::AREA_W'(rw * rh);
			res.placed = 1'b1;
			res.pos_x = e.x;
			res.pos_y = e.y;
		end
		res.filled_area = area_sum;
		return res;
	endfunction

	function automatic void check_field(input string fname, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			mismatches++;
		end
	endfunction

	// Driver: holds start with the queue head until the packer takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				placements_due.push_back(place_rect(req));
				void'(pending_rects.pop_front());
				accepted_rects++;
				if (accepted_rects % 64 == 0)
					calm = ($urandom_range(0, 2) == 0);
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_rects.size() != 0) begin
				if (idle_en && !calm && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(1, 16) - 1;
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					req <= pending_rects[0];
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done pulse must match the oldest predicted placement.
	always @(posedge clk) begin
		gtp_pkg::rect_res_t want;
		if (arst_n && done) begin
			if (placements_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				mismatches++;
			end else begin
				want = placements_due.pop_front();
				check_field("placed", want.placed, result.placed);
				check_field("pos_x", want.pos_x, result.pos_x);
				check_field("pos_y", want.pos_y, result.pos_y);
				check_field("store_full", want.store_full, result.store_full);
				check_field("filled_area", want.filled_area, result.filled_area);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_rect(input int w, input int h);
		gtp_pkg::rect_req_t r;
		r.rect_width = gtp_pkg::DIM_W'(w);
		r.rect_height = gtp_pkg::DIM_W'(h);
		pending_rects.push_back(r);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_rects.size() != 0 || start || placements_due.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gtp_pkg::CFG_IDX_W-1:0] idx, input int val);
		logic [gtp_pkg::DIM_W-1:0] v;
		v = gtp_pkg::DIM_W'(val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == gtp_pkg::REG_BIN_WIDTH) begin
			pred_bin_w = (v > gtp_pkg::MAX_DIM) ? gtp_pkg::MAX_DIM : v;
			empty_bin();
		end else if (idx == gtp_pkg::REG_BIN_HEIGHT) begin
			pred_bin_h = (v > gtp_pkg::MAX_DIM) ? gtp_pkg::MAX_DIM : v;
			empty_bin();
		end
	endtask

	function automatic int pick_dim();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return gtp_pkg::MAX_DIM;
			2: return $urandom_range(0, (1 << gtp_pkg::DIM_W) - 1);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	initial begin
		int issued;
		int batch;
		int sel;
		int w;
		int h;
		pred_bin_w = 0;
		pred_bin_h = 0;
		empty_bin();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Right after reset the bin is 0 by 0: only zero-sized requests fit.
		push_rect(0, 0);
		push_rect(1, 0);
		push_rect(0, 0);
		wait_idle();

		write_reg(REG_UNMAPPED_LO, 1234);
		write_reg(REG_UNMAPPED_HI, (1 << gtp_pkg::DIM_W) - 1);
		write_reg(gtp_pkg::REG_BIN_WIDTH, (1 << gtp_pkg::DIM_W) - 1);
		write_reg(gtp_pkg::REG_BIN_HEIGHT, gtp_pkg::MAX_DIM);
		push_rect(gtp_pkg::MAX_DIM, gtp_pkg::MAX_DIM);
		push_rect((1 << gtp_pkg::DIM_W) - 1, 1);
		push_rect(0, 0);
		push_rect(1, (1 << gtp_pkg::DIM_W) - 1);
		wait_idle();

		write_reg(gtp_pkg::REG_BIN_WIDTH, 10);
		write_reg(gtp_pkg::REG_BIN_HEIGHT, 6);
		push_rect(3, 5);
		push_rect(4, 1);
		push_rect(10, 6);
		push_rect(2, 2);
		push_rect(7, 1);
		push_rect(0, 3);
		push_rect(5, 0);
		push_rect(1, 1);
		wait_idle();

		write_reg(gtp_pkg::REG_BIN_HEIGHT, 0);
		push_rect(0, 0);
		push_rect(1, 0);
		wait_idle();

		// Zero-sized requests add one piece each until the free list is full.
		write_reg(gtp_pkg::REG_BIN_WIDTH, 100);
		write_reg(gtp_pkg::REG_BIN_HEIGHT, 100);
		for (int i = 0; i < FILL_ITEMS; i++)
			push_rect(0, 0);
		push_rect(0, 0);
		push_rect(1, 1);
		push_rect(100, 100);
		push_rect(101, 1);
		wait_idle();

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 3);
			if (sel != 1)
				write_reg(gtp_pkg::REG_BIN_WIDTH, pick_dim());
			if (sel != 0)
				write_reg(gtp_pkg::REG_BIN_HEIGHT, pick_dim());
			if (sel == 3)
				write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
					$urandom_range(0, (1 << gtp_pkg::DIM_W) - 1));
			batch = $urandom_range(5, 40);
			for (int i = 0; i < batch; i++) begin
				sel = $urandom_range(0, 19);
				if (sel == 0) begin
					w = $urandom_range(0, (1 << gtp_pkg::DIM_W) - 1);
					h = $urandom_range(0, (1 << gtp_pkg::DIM_W) - 1);
				end else if (sel == 1) begin
					w = 0;
					h = 0;
				end else if (sel == 2) begin
					w = $urandom_range(0, pred_bin_w);
					h = pred_bin_h;
				end else if (sel < 6) begin
					w = $urandom_range(0, pred_bin_w + 1);
					h = $urandom_range(0, pred_bin_h + 1);
				end else begin
					w = $urandom_range(0, pred_bin_w / 3 + 1);
					h = $urandom_range(0, pred_bin_h / 3 + 1);
				end
				push_rect(w, h);
				issued++;
			end
			if (issued >= RANDOM_ITEMS * 4 / 5)
				idle_en = 1'b0;
			wait_idle();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: guillotine_rect_packer.f
rtl/gtp_pkg.sv
rtl/gtp_ram.sv
rtl/gtp_split.sv
rtl/guillotine_rect_packer.sv
test/guillotine_rect_packer_tb.sv
